@@ design/assert_macros.svh @@
// Assertion macros for the checker file of the Sobel gradient block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied
`define SGM_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sgm_pkg.sv @@
// Package for the Sobel gradient block: field widths, register codes, state type,
// kernel coefficients and width helpers. No dependencies.
package sgm_pkg;

    // Port field widths
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int MAG_BITS    = 11;
    localparam int GRAD_BITS   = 11;
    localparam int ROW_BITS    = 12;
    localparam int COL_BITS    = 10;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    // Frame dimension limits
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    // Reset values of the registers
    localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Register index, taken from paddr bit 2
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQR,
        ST_ROOT,
        ST_EMIT
    } t_state;

    // Window control from the sequencer
    typedef struct packed {
        logic shift;
        logic grad;
    } t_win_ctl;

    // Sobel kernels, row 0 is the oldest line, column 0 the oldest pixel
    typedef int t_kernel [3][3];
    localparam t_kernel SOBEL_GX = '{'{1, 0, -1}, '{2, 0, -2}, '{1, 0, -1}};
    localparam t_kernel SOBEL_GY = '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}};

    // Width of the squared sum, wrapped at 32 bits
    function automatic int sum_bits(int pix_bits);
        int full;
        full = 2 * (pix_bits + 2) + 1;
        if (full > 32) full = 32;
        return full;
    endfunction

    // Width of the integer square root of that sum
    function automatic int root_bits(int pix_bits);
        return (sum_bits(pix_bits) + 1) >> 1;
    endfunction

endpackage

@@ design/sgm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sgm_win.sv @@
// 3x3 pixel window and both Sobel kernels, gradients registered.
// Depends on sgm_pkg (kernels, window control struct).
module sgm_win import sgm_pkg::*; #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_win_ctl                     i_ctl,
    input  logic [PIXEL_BITS-1:0]        i_up,
    input  logic [PIXEL_BITS-1:0]        i_mid,
    input  logic [PIXEL_BITS-1:0]        i_pix,
    output logic signed [PIXEL_BITS+2:0] o_gx,
    output logic signed [PIXEL_BITS+2:0] o_gy
);

    localparam int GW = PIXEL_BITS + 3;

    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic signed [GW-1:0]  r_gx;
    logic signed [GW-1:0]  r_gy;
    logic signed [GW-1:0]  n_gx;
    logic signed [GW-1:0]  n_gy;

    // Window shift: columns move left, new column from the line stores and the new pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_up;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_pix;
        end
    end

    // Kernel sums over the nine taps
    always_comb begin
        n_gx = '0;
        n_gy = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_gx = n_gx + GW'(SOBEL_GX[i][j]) * GW'(signed'({1'b0, r_win[i][j]}));
                n_gy = n_gy + GW'(SOBEL_GY[i][j]) * GW'(signed'({1'b0, r_win[i][j]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.grad) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
        end
    end

    assign o_gx = r_gx;
    assign o_gy = r_gy;

endmodule

@@ design/sgm_mag.sv @@
// Gradient magnitude: squares and sum combinational, then an iterative integer
// square root, one result bit per cycle. Depends on sgm_pkg (width helpers).
module sgm_mag import sgm_pkg::*; #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [PIXEL_BITS+2:0]         i_gx,
    input  logic signed [PIXEL_BITS+2:0]         i_gy,
    output logic                                 o_done,
    output logic [root_bits(PIXEL_BITS)-1:0]     o_root
);

    localparam int GW = PIXEL_BITS + 3;
    localparam int AW = PIXEL_BITS + 2;
    localparam int FW = 2 * AW + 1;
    localparam int SW = sum_bits(PIXEL_BITS);
    localparam int RW = root_bits(PIXEL_BITS);
    localparam int NW = $clog2(RW + 1);
    localparam logic [SW-1:0] TOP_BIT = SW'(1) << (2 * (RW - 1));

    logic [AW-1:0]    w_ax;
    logic [AW-1:0]    w_ay;
    logic [2*AW-1:0]  w_sqx;
    logic [2*AW-1:0]  w_sqy;
    logic [FW-1:0]    w_sum;
    logic [SW:0]      w_trial;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_res;
    logic [SW-1:0]    r_bit;
    logic [NW-1:0]    r_cnt;
    logic             r_done;

    // Absolute values and squared sum, wrapping at 32 bits
    always_comb begin
        w_ax  = i_gx[GW-1] ? AW'(-i_gx) : AW'(i_gx);
        w_ay  = i_gy[GW-1] ? AW'(-i_gy) : AW'(i_gy);
        w_sqx = w_ax * w_ax;
        w_sqy = w_ay * w_ay;
        w_sum = FW'(w_sqx) + FW'(w_sqy);
    end

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};

    // Iteration counter and completion flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= NW'(RW);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == NW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    // One restoring step of the digit-by-digit root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(w_sum);
            r_res <= '0;
            r_bit <= TOP_BIT;
        end else if (r_cnt != '0) begin
            if ({1'b0, r_rem} >= w_trial) begin
                r_rem <= r_rem - SW'(w_trial);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[RW-1:0];

endmodule

@@ design/sobel_gradient_magnitude.sv @@
// Top level of the streaming 3x3 Sobel gradient block: counters, register port,
// line stores, sequencer and output register. Depends on sgm_pkg, sgm_ram,
// sgm_win and sgm_mag.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  pixel in | i_valid / o_stall   | i_pixel
//  result   | o_valid / i_stall   | o_magnitude o_grad_x o_grad_y o_out_row
//           |                     | o_out_col o_frame_done
//  config   | psel penable pwrite | paddr pwdata prdata (pready tied high)
//
// A pixel that yields no result passes through ST_LOAD only; one that yields a result
// also passes ST_GRAD, ST_SQR, ST_ROOT (where the square-root unit resolves one result
// bit per cycle) and ST_EMIT. One request is in work at a time; o_stall is high from
// acceptance until the sequencer is back in ST_IDLE, after ST_LOAD or after the result
// is loaded into the output register, which then waits for the consumer.
// Synchronous active-low reset clears the sequencer, counters, registers and
// output valid; the line stores are not cleared and need no clearing pass.
module sobel_gradient_magnitude import sgm_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [PIXEL_BITS-1:0]       i_pixel,
    // result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [MAG_BITS-1:0]         o_magnitude,
    output logic signed [GRAD_BITS-1:0] o_grad_x,
    output logic signed [GRAD_BITS-1:0] o_grad_y,
    output logic [ROW_BITS-1:0]         o_out_row,
    output logic [COL_BITS-1:0]         o_out_col,
    output logic                        o_frame_done,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [CFG_ADDR_BITS-1:0]    paddr,
    input  logic [CFG_DATA_BITS-1:0]    pwdata,
    output logic [CFG_DATA_BITS-1:0]    prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = PIXEL_BITS + 3;
    localparam int RW = root_bits(PIXEL_BITS);

    t_state r_state;
    t_state n_state;

    logic [WIDTH_BITS-1:0]  r_frame_width;
    logic [HEIGHT_BITS-1:0] r_frame_height;
    logic [CW:0]            w_width_eff;
    logic [HEIGHT_BITS-1:0] w_height_eff;
    logic                   w_cfg_write;

    logic [CW-1:0]          r_col;
    logic [ROW_BITS-1:0]    r_row;
    logic [CW:0]            w_col_next;
    logic [HEIGHT_BITS-1:0] w_row_next;
    logic                   w_accept;

    // request in work
    logic [CW-1:0]          r_c;
    logic [ROW_BITS-1:0]    r_r;
    logic [PIXEL_BITS-1:0]  r_pix;
    logic                   r_prod;
    logic                   r_last;

    logic [PIXEL_BITS-1:0]  w_up_rd;
    logic [PIXEL_BITS-1:0]  w_mid_rd;
    logic                   w_store_we;
    t_win_ctl               w_win_ctl;
    logic signed [GW-1:0]   w_gx;
    logic signed [GW-1:0]   w_gy;
    logic                   w_mag_start;
    logic                   w_mag_done;
    logic [RW-1:0]          w_root;
    logic                   w_emit;

    logic [31:0]            w_root32;
    logic signed [31:0]     w_gx32;
    logic signed [31:0]     w_gy32;
    logic [31:0]            w_col_m1;

    // output register
    logic                        r_out_valid;
    logic [MAG_BITS-1:0]         r_mag;
    logic signed [GRAD_BITS-1:0] r_gx;
    logic signed [GRAD_BITS-1:0] r_gy;
    logic [ROW_BITS-1:0]         r_orow;
    logic [COL_BITS-1:0]         r_ocol;
    logic                        r_odone;

    // ---------------- register port ----------------
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (w_cfg_write) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Effective dimensions, clamped to the supported range
    always_comb begin
        if (32'(r_frame_width) < MIN_DIM) begin
            w_width_eff = (CW+1)'(MIN_DIM);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_width_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_width_eff = (CW+1)'(r_frame_width);
        end
        if (32'(r_frame_height) < MIN_DIM) begin
            w_height_eff = HEIGHT_BITS'(MIN_DIM);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            w_height_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            w_height_eff = r_frame_height;
        end
    end

    // ---------------- position counters ----------------
    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_col_next = {1'b0, r_col} + (CW+1)'(1);
    assign w_row_next = {1'b0, r_row} + HEIGHT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_write) begin
            // a register write restarts the frame
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_col_next >= w_width_eff) begin
                r_col <= '0;
                r_row <= (w_row_next >= w_height_eff) ? '0 : w_row_next[ROW_BITS-1:0];
            end else begin
                r_col <= w_col_next[CW-1:0];
            end
        end
    end

    // Latch the accepted pixel and its position
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c    <= r_col;
            r_r    <= r_row;
            r_pix  <= i_pixel;
            r_prod <= (r_row >= ROW_BITS'(2)) && (r_col >= CW'(2));
            r_last <= (w_row_next == w_height_eff) && (w_col_next == w_width_eff);
        end
    end

    // ---------------- line stores ----------------
    // read at acceptance, write back the shifted column in the following cycle
    assign w_store_we = (r_state == ST_LOAD);

    sgm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_c),
        .i_wdata (w_mid_rd),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_up_rd)
    );

    sgm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_c),
        .i_wdata (r_pix),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_mid_rd)
    );

    // ---------------- window, kernels, magnitude ----------------
    assign w_win_ctl.shift = (r_state == ST_LOAD);
    assign w_win_ctl.grad  = (r_state == ST_GRAD);
    assign w_mag_start     = (r_state == ST_SQR);

    sgm_win #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_win_ctl),
        .i_up    (w_up_rd),
        .i_mid   (w_mid_rd),
        .i_pix   (r_pix),
        .o_gx    (w_gx),
        .o_gy    (w_gy)
    );

    sgm_mag #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mag_start),
        .i_gx    (w_gx),
        .i_gy    (w_gy),
        .o_done  (w_mag_done),
        .o_root  (w_root)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = r_prod ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                n_state = ST_SQR;
            end
            ST_SQR: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (w_mag_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // load once the output register is free or being taken
                if (!r_out_valid || !i_stall) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    assign w_root32 = 32'(w_root);
    assign w_gx32   = 32'(w_gx);
    assign w_gy32   = 32'(w_gy);
    assign w_col_m1 = 32'(r_c) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_mag   <= w_root32[MAG_BITS-1:0];
            r_gx    <= w_gx32[GRAD_BITS-1:0];
            r_gy    <= w_gy32[GRAD_BITS-1:0];
            r_orow  <= r_r - ROW_BITS'(1);
            r_ocol  <= w_col_m1[COL_BITS-1:0];
            r_odone <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_magnitude  = r_mag;
    assign o_grad_x     = r_gx;
    assign o_grad_y     = r_gy;
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_frame_done = r_odone;

endmodule

@@ design/sgm_checker.sv @@
// Port-level checker for the Sobel gradient block, bound to the top level.
// Depends on sgm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgm_checker import sgm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [MAG_BITS-1:0]         o_magnitude,
    input  logic signed [GRAD_BITS-1:0] o_grad_x,
    input  logic signed [GRAD_BITS-1:0] o_grad_y,
    input  logic [ROW_BITS-1:0]         o_out_row,
    input  logic [COL_BITS-1:0]         o_out_col,
    input  logic                        o_frame_done
);

    logic signed [31:0] w_gx;
    logic signed [31:0] w_gy;
    logic [31:0]        w_sq_sum;
    logic [31:0]        w_mag;
    logic [31:0]        w_lo;
    logic [31:0]        w_hi;
    logic               w_root_ok;
    logic               w_in_acc;
    logic               w_wait;
    logic [MAG_BITS+2*GRAD_BITS+ROW_BITS+COL_BITS+1:0] w_bus;

    // Bounds of the root: mag^2 <= gx^2 + gy^2 < (mag + 1)^2
    always_comb begin
        w_gx      = 32'(o_grad_x);
        w_gy      = 32'(o_grad_y);
        w_sq_sum  = 32'(w_gx * w_gx) + 32'(w_gy * w_gy);
        w_mag     = 32'(o_magnitude);
        w_lo      = w_mag * w_mag;
        w_hi      = (w_mag + 32'd1) * (w_mag + 32'd1);
        w_root_ok = (w_lo <= w_sq_sum) && (w_sq_sum < w_hi);
    end

    // Handshake terms and the whole result side, valid included
    always_comb begin
        w_in_acc = i_valid && !o_stall;
        w_wait   = o_valid && i_stall;
        w_bus    = {o_valid, o_magnitude, o_grad_x, o_grad_y, o_out_row, o_out_col,
                    o_frame_done};
    end

    `SGM_ASSERT_SAME(a_mag_is_root, i_clk, i_rst_n, o_valid, w_root_ok, "magnitude wrong")

    // One request at a time: an accepted pixel blocks the input next cycle
    `SGM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_stall, "input not stalled")

    // A waiting result holds still
    `SGM_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_wait, $stable(w_bus), "result changed")

    // Reset empties the output register
    `SGM_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);

@@ bench/tb_sobel_gradient_magnitude.sv @@
`timescale 1ns / 100ps
// Testbench for the streaming 3x3 Sobel gradient block: pixel frames in, gradient
// results predicted in step and compared in order of arrival.
// Depends on sgm_pkg and sobel_gradient_magnitude.
module tb_sobel_gradient_magnitude;
    import sgm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RST_CYCLES     = 12;
    localparam int LINE_LEN       = 1024;
    localparam int PIX_BITS       = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WIDE_COLS      = 160;
    localparam int RAND_ITEMS     = 1200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    // One expected gradient result
    typedef struct packed {
        logic [MAG_BITS-1:0]         mag;
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
        logic [ROW_BITS-1:0]         row;
        logic [COL_BITS-1:0]         col;
        logic                        done;
    } t_grad_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [PIX_BITS-1:0]          i_pixel = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [MAG_BITS-1:0]          o_magnitude;
    logic signed [GRAD_BITS-1:0]  o_grad_x;
    logic signed [GRAD_BITS-1:0]  o_grad_y;
    logic [ROW_BITS-1:0]          o_out_row;
    logic [COL_BITS-1:0]          o_out_col;
    logic                         o_frame_done;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]     paddr = '0;
    logic [CFG_DATA_BITS-1:0]     pwdata = '0;
    logic [CFG_DATA_BITS-1:0]     prdata;
    logic                         pready;

    // Stream control
    logic [PIX_BITS-1:0] pix_queue [$];
    t_grad_res           grad_expect [$];
    logic                px_acc = 1'b0;
    int unsigned         tx_idle_pct = 0;
    int unsigned         rx_stall_pct = 0;
    logic                hold_go = 1'b0;
    logic                rx_hold_on = 1'b0;
    int unsigned         mismatch_cnt = 0;

    // Predictor state: registers, line stores, window, raster position
    logic [WIDTH_BITS-1:0]  frame_w_reg = FRAME_WIDTH_RST;
    logic [HEIGHT_BITS-1:0] frame_h_reg = FRAME_HEIGHT_RST;
    logic [PIX_BITS-1:0]    line_up  [LINE_LEN];
    logic [PIX_BITS-1:0]    line_mid [LINE_LEN];
    logic [PIX_BITS-1:0]    win [3][3];
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;

    sobel_gradient_magnitude uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_magnitude  (o_magnitude),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        foreach (line_up[k]) begin
            line_up[k]  = '0;
            line_mid[k] = '0;
        end
        foreach (win[a, b]) win[a][b] = '0;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Floor square root, one result bit per pass
    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned root;
        int          b;
        root = 0;
        for (b = 11; b >= 0; b--) begin
            if ((root | (1 << b)) * (root | (1 << b)) <= v) root = root | (1 << b);
        end
        return root;
    endfunction

    // Pixel values biased towards the two extremes
    function automatic logic [PIX_BITS-1:0] rand_pixel();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return PIX_BITS'($urandom_range(0, 255));
    endfunction

    // Shift one pixel into the window and work out the result it releases, if any
    task automatic sobel_predict(input logic [PIX_BITS-1:0] pix);
        int unsigned w_eff, h_eff;
        int          left_s, right_s, top_s, bot_s, gx, gy;
        int          i;
        t_grad_res   res;
        w_eff = clamp_dim(32'(frame_w_reg), LINE_LEN);
        h_eff = clamp_dim(32'(frame_h_reg), MAX_HEIGHT);
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_up[col_pos];
        win[1][2] = line_mid[col_pos];
        win[2][2] = pix;
        line_up[col_pos]  = line_mid[col_pos];
        line_mid[col_pos] = pix;

        if (row_pos >= 2 && col_pos >= 2) begin
            left_s  = win[0][0] + 2 * win[1][0] + win[2][0];
            right_s = win[0][2] + 2 * win[1][2] + win[2][2];
            top_s   = win[0][0] + 2 * win[0][1] + win[0][2];
            bot_s   = win[2][0] + 2 * win[2][1] + win[2][2];
            gx = left_s - right_s;
            gy = top_s - bot_s;
            res.mag  = MAG_BITS'(floor_root(gx * gx + gy * gy));
            res.gx   = gx[GRAD_BITS-1:0];
            res.gy   = gy[GRAD_BITS-1:0];
            res.row  = ROW_BITS'(row_pos - 1);
            res.col  = COL_BITS'(col_pos - 1);
            res.done = (row_pos == h_eff - 1) && (col_pos == w_eff - 1);
            grad_expect.push_back(res);
        end

        // raster position wraps at the end of the line and of the frame
        col_pos++;
        if (col_pos >= w_eff) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h_eff) row_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Pixel driver: next request once the current one has gone in
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || px_acc) begin
            if (pix_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_valid <= 1'b1;
                i_pixel <= pix_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= rx_hold_on || ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Long hold-off on the result side while pixels keep coming
    initial begin : rx_long_hold
        wait (hold_go);
        @(negedge i_clk);
        rx_hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        rx_hold_on <= 1'b0;
    end

    // Monitor: check results against the oldest expectation, then capture requests
    always @(posedge i_clk) begin
        t_grad_res want;
        if (!i_rst_n) begin
            px_acc <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (grad_expect.size() == 0) begin
                    report_mismatch("unexpected result, out_col", int'(o_out_col), -1);
                end else begin
                    want = grad_expect.pop_front();
                    if (o_magnitude !== want.mag)
                        report_mismatch("magnitude", int'(o_magnitude), int'(want.mag));
                    if (o_grad_x !== want.gx)
                        report_mismatch("grad_x", int'(o_grad_x), int'(want.gx));
                    if (o_grad_y !== want.gy)
                        report_mismatch("grad_y", int'(o_grad_y), int'(want.gy));
                    if (o_out_row !== want.row)
                        report_mismatch("out_row", int'(o_out_row), int'(want.row));
                    if (o_out_col !== want.col)
                        report_mismatch("out_col", int'(o_out_col), int'(want.col));
                    if (o_frame_done !== want.done)
                        report_mismatch("frame_done", int'(o_frame_done), int'(want.done));
                end
            end
            px_acc <= i_valid && !o_stall;
            if (i_valid && !o_stall) sobel_predict(i_pixel);
        end
    end

    // Register write: setup then access; the frame restarts
    task automatic cfg_write(input logic reg_sel, input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_FRAME_WIDTH) frame_w_reg = value[WIDTH_BITS-1:0];
        else frame_h_reg = value[HEIGHT_BITS-1:0];
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
        endcase
    endtask

    // Wait until every pixel is in and every result out, then let the block settle
    task automatic drain_block();
        while (pix_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (grad_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned w_eff, h_eff, n, sel, phase, rand_items;
        int          i;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one wider frame first, written twice to check the second write wins
        set_idle(3);
        cfg_write(REG_FRAME_WIDTH, 1024);
        cfg_write(REG_FRAME_WIDTH, WIDE_COLS);
        cfg_write(REG_FRAME_HEIGHT, 3);
        for (i = 0; i < 3 * WIDE_COLS; i++) pix_queue.push_back(rand_pixel());
        drain_block();

        // directed: both sizes below the minimum, two frames back to back
        set_idle(0);
        cfg_write(REG_FRAME_WIDTH, 0);
        cfg_write(REG_FRAME_HEIGHT, 2);
        for (i = 0; i < 9; i++)
            pix_queue.push_back((i / 3 == 0 || i % 3 == 0) ? 8'hFF : 8'h00);
        for (i = 0; i < 9; i++)
            pix_queue.push_back((i / 3 == 2 || i % 3 == 2) ? 8'hFF : 8'h00);
        // part of a frame, then a register write must restart it
        for (i = 0; i < 4; i++) pix_queue.push_back(8'hFF);
        drain_block();
        cfg_write(REG_FRAME_HEIGHT, 3);
        cfg_write(REG_FRAME_WIDTH, 3);
        for (i = 0; i < 9; i++) pix_queue.push_back((i % 2) ? 8'hAA : 8'h55);
        drain_block();

        // random frames, mostly small, every idling mode in turn
        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            set_idle(phase % 4);
            if (phase == 0) begin
                cfg_write(REG_FRAME_WIDTH, 5);
                cfg_write(REG_FRAME_HEIGHT, 4096);
            end else begin
                sel = $urandom_range(0, 2);
                if (sel != 1) begin
                    n = $urandom_range(0, 9);
                    if (n < 7) cfg_write(REG_FRAME_WIDTH, $urandom_range(3, 9));
                    else if (n < 8) cfg_write(REG_FRAME_WIDTH, $urandom_range(0, 2));
                    else cfg_write(REG_FRAME_WIDTH, $urandom_range(10, 40));
                end
                if (sel != 0) begin
                    n = $urandom_range(0, 9);
                    if (n < 7) cfg_write(REG_FRAME_HEIGHT, $urandom_range(3, 7));
                    else if (n < 8) cfg_write(REG_FRAME_HEIGHT, $urandom_range(0, 2));
                    else cfg_write(REG_FRAME_HEIGHT, $urandom_range(4097, 8191));
                end
            end
            w_eff = clamp_dim(32'(frame_w_reg), LINE_LEN);
            h_eff = clamp_dim(32'(frame_h_reg), MAX_HEIGHT);
            // whole frames plus a tail where the frame is short, else a few rows
            if (h_eff <= 7)
                n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff * h_eff - 1);
            else
                n = w_eff * $urandom_range(3, 8);
            if (phase == 0) n = 200;
            for (i = 0; i < n; i++) pix_queue.push_back(rand_pixel());
            if (phase == 0) hold_go = 1'b1;
            drain_block();
            rand_items += n;
            phase++;
        end

        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sobel_gradient_magnitude.f @@
+incdir+design
design/sgm_pkg.sv
design/sgm_ram.sv
design/sgm_win.sv
design/sgm_mag.sv
design/sobel_gradient_magnitude.sv
design/sgm_checker.sv
bench/tb_sobel_gradient_magnitude.sv
